@@ design/sapr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapr_pkg
// Shared constants for the slewed all-pass phase rotator.
// ----------------------------------------------------------------------------
package sapr_pkg;

  localparam int PHASE_W = 17;
  localparam int SLEW_W  = 17;
  localparam int ITHO_W  = 24;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [PHASE_W-1:0] PHASE_ONE = 17'd65536;
  localparam logic [30:0]        A_MAX     = 31'd1073740750;

  localparam logic [SLEW_W-1:0] SLEW_RESET = 17'd297;
  localparam logic [ITHO_W-1:0] ITHO_RESET = 24'd918397;

  typedef enum logic {
    REG_SLEW_STEP = 1'b0,
    REG_INV_TAN   = 1'b1
  } reg_idx_t;

endpackage

@@ design/slewed_allpass_phase_rotator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slewed_allpass_phase_rotator_top
// First-order all-pass phase rotator with slewed phase control.
// ----------------------------------------------------------------------------
// A sample with a nonzero phase passes from queue to output register through
// the 31-step restoring divider for a and the 32-step square root for b in
// the back sequencer; a sample at zero phase skips both.
// The front slews the phase and queues up to two requests meanwhile.
// Registers: slew_step at byte address 0, inv_tan_half_omega at address 4.
module slewed_allpass_phase_rotator_top #(
  parameter int TAN_TABLE_DEPTH = 1024,
  parameter int SAMPLE_WIDTH    = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sapr_pkg::ADDR_W-1:0]         paddr,
  input  logic [sapr_pkg::DATA_W-1:0]         pwdata,
  output logic [sapr_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
  input  logic [sapr_pkg::PHASE_W-1:0]        target_phase,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out
);

  localparam int IDX_W = $clog2(TAN_TABLE_DEPTH + 1);
  localparam int Q_W   = SAMPLE_WIDTH + 1 + IDX_W;

  logic [sapr_pkg::SLEW_W-1:0] slew_step;
  logic [sapr_pkg::ITHO_W-1:0] inv_tan_half_omega;

  logic                           q_push;
  logic                           q_pop;
  logic                           q_full;
  logic                           q_valid;
  logic [1:0]                     q_count;
  logic signed [SAMPLE_WIDTH-1:0] f_sample;
  logic                           f_zero;
  logic [IDX_W-1:0]               f_idx;
  logic [Q_W-1:0]                 q_out;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slew_step          <= sapr_pkg::SLEW_RESET;
      inv_tan_half_omega <= sapr_pkg::ITHO_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (sapr_pkg::reg_idx_t'(paddr[2]))
        sapr_pkg::REG_SLEW_STEP: slew_step <= pwdata[sapr_pkg::SLEW_W-1:0];
        sapr_pkg::REG_INV_TAN:   inv_tan_half_omega <= pwdata[sapr_pkg::ITHO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sapr_pkg::reg_idx_t'(paddr[2]))
      sapr_pkg::REG_SLEW_STEP: prdata = sapr_pkg::DATA_W'(slew_step);
      sapr_pkg::REG_INV_TAN:   prdata = sapr_pkg::DATA_W'(inv_tan_half_omega);
      default:                 prdata = '0;
    endcase
  end

  sapr_front #(
    .TAN_TABLE_DEPTH(TAN_TABLE_DEPTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .IDX_W(IDX_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample_in(sample_in),
    .target_phase(target_phase),
    .slew_step(slew_step),
    .q_full(q_full),
    .q_push(q_push),
    .q_sample(f_sample),
    .q_zero(f_zero),
    .q_idx(f_idx)
  );

  sapr_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_data({f_sample, f_zero, f_idx}),
    .pop(q_pop),
    .pop_data(q_out),
    .valid(q_valid),
    .full(q_full),
    .count(q_count)
  );

  sapr_back #(
    .TAN_TABLE_DEPTH(TAN_TABLE_DEPTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .IDX_W(IDX_W)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_pop(q_pop),
    .q_sample(q_out[Q_W-1 -: SAMPLE_WIDTH]),
    .q_zero(q_out[IDX_W]),
    .q_idx(q_out[IDX_W-1:0]),
    .inv_tan_half_omega(inv_tan_half_omega),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample_out(sample_out)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst) q_count != 2'd3)
    else $error("queue count out of range");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> q_count != 2'd0)
    else $error("accepted request not queued");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_count != 2'd0)
    else $error("pop from empty queue");

endmodule

@@ design/sapr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapr_front
// Accepts requests, slews the phase toward the target and classifies the
// request as bypass or lattice, with the tangent table index.
// ----------------------------------------------------------------------------
module sapr_front #(
  parameter int TAN_TABLE_DEPTH = 1024,
  parameter int SAMPLE_WIDTH    = 24,
  parameter int IDX_W           = 11
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_in,
  input  logic [sapr_pkg::PHASE_W-1:0]         target_phase,
  input  logic [sapr_pkg::SLEW_W-1:0]          slew_step,
  input  logic                                 q_full,
  output logic                                 q_push,
  output logic signed [SAMPLE_WIDTH-1:0]       q_sample,
  output logic                                 q_zero,
  output logic [IDX_W-1:0]                     q_idx
);

  localparam int PROD_W = sapr_pkg::PHASE_W + $clog2(TAN_TABLE_DEPTH) + 2;

  logic [sapr_pkg::PHASE_W-1:0] current_phase;
  logic [sapr_pkg::PHASE_W-1:0] current_phase_next;
  logic [sapr_pkg::PHASE_W-1:0] target;
  logic [sapr_pkg::PHASE_W-1:0] diff;
  logic [PROD_W-1:0]            idx_full;

  always_comb begin
    target = (target_phase > sapr_pkg::PHASE_ONE) ? sapr_pkg::PHASE_ONE : target_phase;
    current_phase_next = current_phase;
    diff = '0;
    if (slew_step == '0) begin
      current_phase_next = target;
    end else if (current_phase < target) begin
      diff = target - current_phase;
      current_phase_next = (diff > slew_step) ? current_phase + slew_step : target;
    end else if (current_phase > target) begin
      diff = current_phase - target;
      current_phase_next = (diff > slew_step) ? current_phase - slew_step : target;
    end
    idx_full = (PROD_W'(current_phase_next) * PROD_W'(TAN_TABLE_DEPTH)
                + PROD_W'(32768)) >> 16;
    if (idx_full > PROD_W'(TAN_TABLE_DEPTH)) begin
      idx_full = PROD_W'(TAN_TABLE_DEPTH);
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_sample = sample_in;
  assign q_zero   = (current_phase_next == '0);
  assign q_idx    = idx_full[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      current_phase <= '0;
    end else if (q_push) begin
      current_phase <= current_phase_next;
    end
  end

endmodule

@@ design/sapr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapr_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module sapr_queue #(
  parameter int WIDTH = 36
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             valid,
  output logic             full,
  output logic [1:0]       count
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;

  assign valid    = (count != 2'd0);
  assign full     = (count == 2'd2);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ design/sapr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sapr_back
// Sequencer that looks up the tangent, divides for a, takes the root for b,
// runs the lattice and holds the result in an output register.
// ----------------------------------------------------------------------------
module sapr_back #(
  parameter int TAN_TABLE_DEPTH = 1024,
  parameter int SAMPLE_WIDTH    = 24,
  parameter int IDX_W           = 11
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  output logic                            q_pop,
  input  logic signed [SAMPLE_WIDTH-1:0]  q_sample,
  input  logic                            q_zero,
  input  logic [IDX_W-1:0]                q_idx,
  input  logic [sapr_pkg::ITHO_W-1:0]     inv_tan_half_omega,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]  sample_out
);

  localparam logic [63:0] PI4_Q62  = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI4_STEP = PI4_Q62 / TAN_TABLE_DEPTH;
  localparam logic [63:0] PI4_REM  = PI4_Q62 % TAN_TABLE_DEPTH;
  localparam int R_W  = 17 + sapr_pkg::ITHO_W;
  localparam int D_W  = R_W + 3;
  localparam int P_W  = SAMPLE_WIDTH + 32;
  localparam int S_W  = P_W + 1;
  localparam logic signed [S_W-1:0] SAT_HI = S_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [S_W-1:0] SAT_LO = -SAT_HI - S_W'(1);

  typedef logic [16:0] rom_t [TAN_TABLE_DEPTH + 1];

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[125:62];
  endfunction

  function automatic rom_t tan_rom_init();
    rom_t t;
    logic [63:0] x, x2, s, c, ts, tc, q, rem;
    for (int i = 0; i <= TAN_TABLE_DEPTH; i++) begin
      x  = PI4_STEP * 64'(i) + (PI4_REM * 64'(i)) / TAN_TABLE_DEPTH;
      x2 = mul_q62(x, x);
      s  = x;
      c  = 64'd1 << 62;
      ts = x;
      tc = 64'd1 << 62;
      for (int k = 1; k < 40; k++) begin
        if (ts != 0 || tc != 0) begin
          ts = mul_q62(ts, x2) / 64'((2 * k) * (2 * k + 1));
          tc = mul_q62(tc, x2) / 64'((2 * k - 1) * (2 * k));
          if (k % 2 == 1) begin
            s = s - ts;
            c = c - tc;
          end else begin
            s = s + ts;
            c = c + tc;
          end
        end
      end
      q = 0;
      rem = s;
      if (rem >= c) begin
        q = 1;
        rem = rem - c;
      end
      for (int n = 0; n < 17; n++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= c) begin
          rem = rem - c;
          q = q | 64'd1;
        end
      end
      t[i] = 17'((q + 1) >> 1);
    end
    return t;
  endfunction

  localparam rom_t TAN_ROM = tan_rom_init();

  typedef enum logic [3:0] {
    S_IDLE, S_ROM, S_MUL, S_DSET, S_DIV, S_ASGN, S_ASQ, S_QSET, S_SQRT,
    S_BSET, S_M1, S_M2, S_M3, S_M4, S_M5, S_DONE
  } state_t;

  state_t                          state;
  logic [IDX_W-1:0]                idx;
  logic [16:0]                     rom_data;
  logic signed [SAMPLE_WIDTH-1:0]  x;
  logic signed [SAMPLE_WIDTH-1:0]  s;
  logic signed [SAMPLE_WIDTH-1:0]  y;
  logic [R_W-1:0]                  r;
  logic [D_W-1:0]                  den;
  logic [D_W-1:0]                  rem;
  logic [32:0]                     q;
  logic [5:0]                      cnt;
  logic signed [31:0]              a;
  logic [30:0]                     amag;
  logic [61:0]                     asq;
  logic [63:0]                     v;
  logic [63:0]                     res;
  logic [63:0]                     sbit;
  logic signed [31:0]              b;
  logic signed [P_W-1:0]           p1;
  logic signed [P_W-1:0]           p2;

  logic [D_W-1:0]    mag;
  logic [D_W-1:0]    rem_sh;
  logic [32:0]       qr;
  logic [30:0]       qmag;
  logic [63:0]       rb;
  logic signed [S_W-1:0] y_sum;
  logic signed [S_W-1:0] s_sum;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic signed [SAMPLE_WIDTH-1:0] s_sat;

  function automatic logic signed [SAMPLE_WIDTH-1:0] rnd_sat(logic signed [S_W-1:0] v_in);
    logic signed [S_W-1:0] t;
    t = (v_in + S_W'(1 << 29)) >>> 30;
    if (t > SAT_HI) t = SAT_HI;
    else if (t < SAT_LO) t = SAT_LO;
    return t[SAMPLE_WIDTH-1:0];
  endfunction

  always_comb begin
    mag    = (D_W'(r) > (D_W'(1) << 32)) ? D_W'(r) - (D_W'(1) << 32)
                                         : (D_W'(1) << 32) - D_W'(r);
    rem_sh = rem << 1;
    qr     = (q + 33'd1) >> 1;
    qmag   = (qr > 33'(sapr_pkg::A_MAX)) ? sapr_pkg::A_MAX : qr[30:0];
    rb     = res + sbit;
    y_sum  = S_W'(p1) + S_W'(p2);
    s_sum  = S_W'(p1) - S_W'(p2);
    y_sat  = rnd_sat(y_sum);
    s_sat  = rnd_sat(s_sum);
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    rom_data <= TAN_ROM[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      s         <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            x   <= q_sample;
            y   <= q_sample;
            idx <= q_idx;
            if (q_zero) begin
              s     <= '0;
              state <= S_DONE;
            end else begin
              state <= S_ROM;
            end
          end
        end
        S_ROM: state <= S_MUL;
        S_MUL: begin
          r     <= R_W'(rom_data * inv_tan_half_omega);
          state <= S_DSET;
        end
        S_DSET: begin
          den <= (D_W'(1) << 32) + D_W'(r);
          if (mag >= (D_W'(1) << 32) + D_W'(r)) begin
            q   <= 33'd1;
            rem <= mag - ((D_W'(1) << 32) + D_W'(r));
          end else begin
            q   <= 33'd0;
            rem <= mag;
          end
          cnt   <= 6'd31;
          state <= S_DIV;
        end
        S_DIV: begin
          if (rem_sh >= den) begin
            rem <= rem_sh - den;
            q   <= {q[31:0], 1'b1};
          end else begin
            rem <= rem_sh;
            q   <= {q[31:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) state <= S_ASGN;
        end
        S_ASGN: begin
          amag  <= qmag;
          a     <= (r > (R_W'(1) << 32)) ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
          state <= S_ASQ;
        end
        S_ASQ: begin
          asq   <= amag * amag;
          state <= S_QSET;
        end
        S_QSET: begin
          v     <= ((64'd1 << 60) - 64'(asq)) << 2;
          res   <= '0;
          sbit  <= 64'd1 << 62;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (v >= rb) begin
            v   <= v - rb;
            res <= (res >> 1) + sbit;
          end else begin
            res <= res >> 1;
          end
          sbit <= sbit >> 2;
          if (sbit == 64'd1) state <= S_BSET;
        end
        S_BSET: begin
          b     <= 32'((res + 64'd1) >> 1);
          state <= S_M1;
        end
        S_M1: begin
          p1    <= P_W'(a * x);
          state <= S_M2;
        end
        S_M2: begin
          p2    <= P_W'(b * s);
          state <= S_M3;
        end
        S_M3: begin
          y     <= y_sat;
          p1    <= P_W'(b * x);
          state <= S_M4;
        end
        S_M4: begin
          p2    <= P_W'(a * s);
          state <= S_M5;
        end
        S_M5: begin
          s     <= s_sat;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            sample_out <= y;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ test/tb_slewed_allpass_phase_rotator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slewed_allpass_phase_rotator_top
// Checks the slewed all-pass phase rotator against an in-bench predictor of
// the slewed phase, tangent lookup, lattice coefficients and lattice state.
// Directed requests hit field extremes and corner settings. Random requests
// run under several register settings, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_slewed_allpass_phase_rotator_top;

  localparam int TAN_DEPTH = 1024;
  localparam int SW = 24;
  localparam int CYCLE_LIMIT = 4000000;
  localparam longint unsigned PI4_Q62 = 64'h3243F6A8885A308D;
  localparam longint unsigned ONE_Q62 = 64'h4000000000000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [sapr_pkg::ADDR_W-1:0] paddr = '0;
  logic [sapr_pkg::DATA_W-1:0] pwdata = '0;
  logic [sapr_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SW-1:0] sample_in = '0;
  logic [sapr_pkg::PHASE_W-1:0] target_phase = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SW-1:0] sample_out;

  slewed_allpass_phase_rotator_top #(
    .TAN_TABLE_DEPTH(TAN_DEPTH),
    .SAMPLE_WIDTH(SW)
  ) dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .sample_in(sample_in),
    .target_phase(target_phase), .out_valid(out_valid), .out_ready(out_ready),
    .sample_out(sample_out)
  );

  always #6 clk = ~clk;

  logic [SW-1:0] expected_samples[$];
  longint unsigned tan_table[0:TAN_DEPTH];
  logic [sapr_pkg::PHASE_W-1:0] phase_q;
  longint lattice_q;
  logic [sapr_pkg::SLEW_W-1:0] slew_q;
  logic [sapr_pkg::ITHO_W-1:0] itho_q;
  int errors = 0;
  int cycles = 0;
  int stall_left = 0;

  function automatic longint unsigned mul_q62(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic longint unsigned tan_q16(longint unsigned i);
    longint unsigned x, x2, s, c, ts, tc, k, q, rem;
    x = (PI4_Q62 / TAN_DEPTH) * i + ((PI4_Q62 % TAN_DEPTH) * i) / TAN_DEPTH;
    x2 = mul_q62(x, x);
    s = x; c = ONE_Q62; ts = x; tc = ONE_Q62;
    for (k = 1; k < 40 && (ts != 0 || tc != 0); k++) begin
      ts = mul_q62(ts, x2) / ((2 * k) * (2 * k + 1));
      tc = mul_q62(tc, x2) / ((2 * k - 1) * (2 * k));
      if (k[0]) begin
        s -= ts; c -= tc;
      end else begin
        s += ts; c += tc;
      end
    end
    q = 0;
    rem = s;
    if (rem >= c) begin
      q = 1; rem -= c;
    end
    for (int n = 0; n < 17; n++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= c) begin
        rem -= c; q |= 1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv; res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint sat_round(longint v);
    longint t;
    t = (v + (64'sd1 <<< 29)) >>> 30;
    if (t > 64'sd8388607) return 64'sd8388607;
    if (t < -64'sd8388608) return -64'sd8388608;
    return t;
  endfunction

  function automatic logic [SW-1:0] rotate_sample(logic signed [SW-1:0] xs,
                                                  logic [sapr_pkg::PHASE_W-1:0] tgt_in);
    longint unsigned idx, r, den, mag, q, rem, one;
    longint x, a, b, y;
    logic [sapr_pkg::PHASE_W-1:0] tgt;
    one = 64'd1 << 32;
    x = longint'(xs);
    tgt = (tgt_in > sapr_pkg::PHASE_ONE) ? sapr_pkg::PHASE_ONE : tgt_in;
    if (slew_q == 0) phase_q = tgt;
    else if (phase_q < tgt)
      phase_q = (tgt - phase_q > slew_q) ? phase_q + slew_q : tgt;
    else if (phase_q > tgt)
      phase_q = (phase_q - tgt > slew_q) ? phase_q - slew_q : tgt;
    if (phase_q == 0) begin
      lattice_q = 0;
      return xs;
    end
    idx = (longint'(phase_q) * TAN_DEPTH + 32768) >> 16;
    if (idx > TAN_DEPTH) idx = TAN_DEPTH;
    r = tan_table[idx] * longint'(itho_q);
    den = one + r;
    mag = (r > one) ? r - one : one - r;
    q = 0;
    rem = mag;
    if (rem >= den) begin
      q = 1; rem -= den;
    end
    for (int n = 0; n < 31; n++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem -= den; q |= 1;
      end
    end
    a = longint'((q + 1) >> 1);
    if (a > longint'(sapr_pkg::A_MAX)) a = longint'(sapr_pkg::A_MAX);
    if (r > one) a = -a;
    b = longint'((int_sqrt(((64'd1 << 60) - longint'(a * a)) << 2) + 1) >> 1);
    y = sat_round(a * x + b * lattice_q);
    lattice_q = sat_round(b * x - a * lattice_q);
    return y[SW-1:0];
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_slewed_allpass_phase_rotator_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_ready <= 1'b1;
    end
  end

  // results move at the next rising edge when both are high at the falling one
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %0d", sample_out);
      end else if (expected_samples[0] !== sample_out) begin
        errors++;
        if (errors <= 10)
          $display("sample_out mismatch: expected %0d actual %0d",
                   $signed(expected_samples[0]), sample_out);
        void'(expected_samples.pop_front());
      end else begin
        void'(expected_samples.pop_front());
      end
    end
  end

  task automatic write_reg(sapr_pkg::reg_idx_t idx, logic [sapr_pkg::DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= sapr_pkg::ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == sapr_pkg::REG_SLEW_STEP) slew_q = value[sapr_pkg::SLEW_W-1:0];
    else itho_q = value[sapr_pkg::ITHO_W-1:0];
  endtask

  task automatic send_sample(logic signed [SW-1:0] x, logic [sapr_pkg::PHASE_W-1:0] tgt,
                             bit allow_gap = 1'b1);
    bit accepted;
    int gap;
    in_valid <= 1'b1;
    sample_in <= x;
    target_phase <= tgt;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk);
      accepted = in_ready;
      if (accepted) expected_samples.push_back(rotate_sample(x, tgt));
      @(posedge clk);
    end
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic test_directed();
    write_reg(sapr_pkg::REG_SLEW_STEP, 0);
    write_reg(sapr_pkg::REG_INV_TAN, sapr_pkg::DATA_W'(sapr_pkg::ITHO_RESET));
    send_sample(24'sh7FFFFF, 17'd65536);
    send_sample(-24'sh800000, 17'd65536);
    send_sample(24'sh000000, 17'd65536);
    send_sample(24'sh7FFFFF, 17'd0);
    send_sample(-24'sh800000, 17'd131071);
    send_sample(24'sh7FFFFF, 17'd100000);
    send_sample(24'sd1234, 17'd1);
    send_sample(-24'sd5, 17'd32768);
    send_sample(-24'sh800000, 17'd0);
    send_sample(24'sh7FFFFF, 17'd1);
    wait_drained();
    write_reg(sapr_pkg::REG_INV_TAN, 0);
    send_sample(24'sh7FFFFF, 17'd40000);
    send_sample(-24'sh800000, 17'd65536);
    send_sample(24'sd77, 17'd0);
    wait_drained();
    write_reg(sapr_pkg::REG_INV_TAN, 32'hFFFFFF);
    send_sample(24'sh7FFFFF, 17'd65536);
    send_sample(-24'sh800000, 17'd65536);
    send_sample(24'sh7FFFFF, 17'd2);
    wait_drained();
    write_reg(sapr_pkg::REG_SLEW_STEP, 1);
    write_reg(sapr_pkg::REG_INV_TAN, 1);
    send_sample(24'sh7FFFFF, 17'd65536);
    send_sample(-24'sh800000, 17'd65536);
    send_sample(24'sh123456, 17'd0);
    wait_drained();
    write_reg(sapr_pkg::REG_SLEW_STEP, 32'd65536);
    send_sample(24'sh7FFFFF, 17'd65536);
    send_sample(-24'sh800000, 17'd0);
    send_sample(24'sh400000, 17'd65535);
    wait_drained();
  endtask

  task automatic test_random_phase(logic [sapr_pkg::SLEW_W-1:0] slew,
                                   logic [sapr_pkg::ITHO_W-1:0] itho, int count);
    logic [sapr_pkg::PHASE_W-1:0] tgt;
    logic signed [SW-1:0] x;
    int run_left, p;
    write_reg(sapr_pkg::REG_SLEW_STEP, sapr_pkg::DATA_W'(slew));
    write_reg(sapr_pkg::REG_INV_TAN, sapr_pkg::DATA_W'(itho));
    run_left = 0;
    tgt = '0;
    for (int n = 0; n < count; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 40);
        p = $urandom_range(0, 9);
        if (p == 0) tgt = '0;
        else if (p == 1) tgt = sapr_pkg::PHASE_ONE;
        else tgt = sapr_pkg::PHASE_W'($urandom_range(0, 65536));
      end
      run_left--;
      p = $urandom_range(0, 19);
      if (p == 0) x = 24'sh7FFFFF;
      else if (p == 1) x = -24'sh800000;
      else x = SW'($urandom);
      if ($urandom_range(0, 9) == 0)
        send_sample(x, sapr_pkg::PHASE_W'($urandom_range(0, 131071)));
      else send_sample(x, tgt);
    end
    wait_drained();
  endtask

  task automatic test_drain_pause();
    for (int n = 0; n < 30; n++)
      send_sample(SW'($urandom), sapr_pkg::PHASE_W'($urandom_range(0, 65536)), 1'b0);
    wait_drained();
    for (int n = 0; n < 30; n++)
      send_sample(SW'($urandom), sapr_pkg::PHASE_W'($urandom_range(0, 65536)), 1'b0);
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i <= TAN_DEPTH; i++) tan_table[i] = tan_q16(64'(i));
    phase_q = '0;
    lattice_q = 0;
    slew_q = sapr_pkg::SLEW_RESET;
    itho_q = sapr_pkg::ITHO_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_random_phase(sapr_pkg::SLEW_RESET, sapr_pkg::ITHO_RESET, 150);
    test_directed();
    test_random_phase(17'd65536, sapr_pkg::ITHO_RESET, 180);
    test_random_phase(17'd1, 24'hFFFFFF, 150);
    test_random_phase(17'd0, 24'd1, 150);
    test_drain_pause();
    test_random_phase(17'd4096, sapr_pkg::ITHO_W'($urandom_range(1, 24'hFFFFFF)), 180);
    test_random_phase(sapr_pkg::SLEW_W'($urandom_range(1, 65536)), 24'd0, 120);
    test_random_phase(sapr_pkg::SLEW_W'($urandom_range(1, 2000)),
                      sapr_pkg::ITHO_W'($urandom_range(1, 3000000)), 200);
    test_random_phase(sapr_pkg::SLEW_RESET, sapr_pkg::ITHO_RESET, 100);
    if (errors == 0) begin
      $display("tb_slewed_allpass_phase_rotator_top: done, clean");
    end else begin
      $display("tb_slewed_allpass_phase_rotator_top: done, errors");
    end
    $finish;
  end

endmodule
